@@ hw/rtl/blk3_pkg.sv @@
package blk3_pkg;

    localparam int ROUNDS    = 7;
    localparam int KEY_REGS  = 4;
    localparam int ADDR_W    = 5;
    localparam int REG_LSB   = 3;

    typedef logic [31:0] word_t;
    typedef logic [63:0] dword_t;
    typedef word_t [15:0] vec16_t;
    typedef dword_t [KEY_REGS-1:0] key_array_t;

    typedef struct packed {
        vec16_t v;
        vec16_t m;
    } work_t;

    typedef struct packed {
        dword_t msg_words_0_1;
        dword_t msg_words_2_3;
        dword_t msg_words_4_5;
        dword_t msg_words_6_7;
        dword_t msg_words_8_9;
        dword_t msg_words_10_11;
        dword_t msg_words_12_13;
        dword_t msg_words_14_15;
    } msg_t;

    typedef struct packed {
        dword_t digest_words_0_1;
        dword_t digest_words_2_3;
        dword_t digest_words_4_5;
        dword_t digest_words_6_7;
    } digest_t;

    localparam logic [3:0][31:0] IV = {
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam word_t BLOCK_LEN   = 32'd64;
    localparam word_t BLOCK_FLAGS = 32'h0000001B;

    localparam logic [15:0][3:0] MSG_PERM = {
        4'd8, 4'd15, 4'd14, 4'd9, 4'd5, 4'd12, 4'd11, 4'd1,
        4'd13, 4'd4, 4'd0, 4'd7, 4'd10, 4'd3, 4'd6, 4'd2
    };

    function automatic word_t rotr16(input word_t x);
        return {x[15:0], x[31:16]};
    endfunction

    function automatic word_t rotr12(input word_t x);
        return {x[11:0], x[31:12]};
    endfunction

    function automatic word_t rotr8(input word_t x);
        return {x[7:0], x[31:8]};
    endfunction

    function automatic word_t rotr7(input word_t x);
        return {x[6:0], x[31:7]};
    endfunction

    // First half of four G functions working on the columns.
    function automatic vec16_t mix_first(input vec16_t v, input vec16_t m);
        vec16_t r;
        word_t  a;
        word_t  b;
        word_t  c;
        word_t  d;
        r = v;
        for (int i = 0; i < 4; i++) begin
            a = v[i] + v[4+i] + m[2*i];
            d = rotr16(v[12+i] ^ a);
            c = v[8+i] + d;
            b = rotr12(v[4+i] ^ c);
            r[i]    = a;
            r[4+i]  = b;
            r[8+i]  = c;
            r[12+i] = d;
        end
        return r;
    endfunction

    // Second half of four G functions working on the columns.
    function automatic vec16_t mix_second(input vec16_t v, input vec16_t m);
        vec16_t r;
        word_t  a;
        word_t  b;
        word_t  c;
        word_t  d;
        r = v;
        for (int i = 0; i < 4; i++) begin
            a = v[i] + v[4+i] + m[2*i+1];
            d = rotr8(v[12+i] ^ a);
            c = v[8+i] + d;
            b = rotr7(v[4+i] ^ c);
            r[i]    = a;
            r[4+i]  = b;
            r[8+i]  = c;
            r[12+i] = d;
        end
        return r;
    endfunction

    // Rotates rows so that the diagonals line up as columns, and brings the
    // upper eight message words into the slots that the column step reads.
    function automatic work_t diagonalize(input work_t w);
        work_t r;
        for (int i = 0; i < 4; i++) begin
            r.v[i]    = w.v[i];
            r.v[4+i]  = w.v[4+((i+1)&3)];
            r.v[8+i]  = w.v[8+((i+2)&3)];
            r.v[12+i] = w.v[12+((i+3)&3)];
        end
        for (int k = 0; k < 16; k++) begin
            r.m[k] = w.m[(k+8)&15];
        end
        return r;
    endfunction

    function automatic work_t undiagonalize(input work_t w);
        work_t r;
        for (int i = 0; i < 4; i++) begin
            r.v[i]                = w.v[i];
            r.v[4+((i+1)&3)]      = w.v[4+i];
            r.v[8+((i+2)&3)]      = w.v[8+i];
            r.v[12+((i+3)&3)]     = w.v[12+i];
        end
        for (int k = 0; k < 16; k++) begin
            r.m[(k+8)&15] = w.m[k];
        end
        return r;
    endfunction

    function automatic work_t permute(input work_t w);
        work_t r;
        r.v = w.v;
        for (int k = 0; k < 16; k++) begin
            r.m[k] = w.m[MSG_PERM[k]];
        end
        return r;
    endfunction

    function automatic work_t init_work(input key_array_t key, input msg_t msg);
        work_t r;
        for (int i = 0; i < KEY_REGS; i++) begin
            r.v[2*i]   = key[i][31:0];
            r.v[2*i+1] = key[i][63:32];
        end
        for (int i = 0; i < 4; i++) begin
            r.v[8+i] = IV[i];
        end
        r.v[12] = '0;
        r.v[13] = '0;
        r.v[14] = BLOCK_LEN;
        r.v[15] = BLOCK_FLAGS;
        r.m[0]  = msg.msg_words_0_1[31:0];
        r.m[1]  = msg.msg_words_0_1[63:32];
        r.m[2]  = msg.msg_words_2_3[31:0];
        r.m[3]  = msg.msg_words_2_3[63:32];
        r.m[4]  = msg.msg_words_4_5[31:0];
        r.m[5]  = msg.msg_words_4_5[63:32];
        r.m[6]  = msg.msg_words_6_7[31:0];
        r.m[7]  = msg.msg_words_6_7[63:32];
        r.m[8]  = msg.msg_words_8_9[31:0];
        r.m[9]  = msg.msg_words_8_9[63:32];
        r.m[10] = msg.msg_words_10_11[31:0];
        r.m[11] = msg.msg_words_10_11[63:32];
        r.m[12] = msg.msg_words_12_13[31:0];
        r.m[13] = msg.msg_words_12_13[63:32];
        r.m[14] = msg.msg_words_14_15[31:0];
        r.m[15] = msg.msg_words_14_15[63:32];
        return r;
    endfunction

    function automatic digest_t fold_digest(input vec16_t v);
        digest_t d;
        d.digest_words_0_1 = {v[1] ^ v[9],  v[0] ^ v[8]};
        d.digest_words_2_3 = {v[3] ^ v[11], v[2] ^ v[10]};
        d.digest_words_4_5 = {v[5] ^ v[13], v[4] ^ v[12]};
        d.digest_words_6_7 = {v[7] ^ v[15], v[6] ^ v[14]};
        return d;
    endfunction

endpackage

@@ hw/rtl/blake3_keyed_block_hash_core.sv @@
// Keyed BLAKE3 compression of one 64-byte block per request.
// The s_ channel carries a request of sixteen message words; the m_ channel
// returns the eight-word digest. Both use valid/ready and a request moves
// when valid and ready are high at a rising edge of aclk.
// The key is held in four 64-bit registers behind the APB port at byte
// addresses 0x00, 0x08, 0x10 and 0x18. Write them only while no request is
// in flight; pready is always high and reads return the stored key.
// Each of the seven rounds is a column step and a diagonal step, and each
// step is split into two register stages, one per half of the G function.
// A request passes through these stages in order and is then loaded into
// the output register, which presents the digest on m_. A new request can
// be accepted every cycle unless a stage stalls; the throughput is set by
// the half-G stage, one per cycle. Each stage stalls on its own, so when the
// receiver holds m_ready low the pipeline keeps filling its empty stages
// and s_ready only drops once the stage behind the input is occupied.
// A synchronous reset (aresetn low) empties the pipeline and clears the key.
module blake3_keyed_block_hash_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  blk3_pkg::msg_t                         s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output blk3_pkg::digest_t                      m_data,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [blk3_pkg::ADDR_W-1:0]            paddr,
    input  logic [63:0]                            pwdata,
    output logic [63:0]                            prdata,
    output logic                                   pready
);

    blk3_pkg::key_array_t key_reg;
    logic [blk3_pkg::ADDR_W-blk3_pkg::REG_LSB-1:0] reg_index;

    logic [blk3_pkg::ROUNDS:0]   rnd_valid;
    logic [blk3_pkg::ROUNDS:0]   rnd_ready;
    blk3_pkg::work_t             rnd_work  [blk3_pkg::ROUNDS+1];
    logic [blk3_pkg::ROUNDS-1:0] mid_valid;
    logic [blk3_pkg::ROUNDS-1:0] mid_ready;
    blk3_pkg::work_t             col_work  [blk3_pkg::ROUNDS];
    blk3_pkg::work_t             diag_in   [blk3_pkg::ROUNDS];
    blk3_pkg::work_t             diag_work [blk3_pkg::ROUNDS];

    logic                        m_valid_reg;
    blk3_pkg::digest_t           m_data_reg;

    assign reg_index = paddr[blk3_pkg::ADDR_W-1:blk3_pkg::REG_LSB];
    assign pready    = 1'b1;
    assign prdata    = key_reg[reg_index];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (psel && penable && pwrite) begin
            key_reg[reg_index] <= pwdata;
        end
    end

    assign rnd_valid[0] = s_valid;
    assign s_ready      = rnd_ready[0];
    assign rnd_work[0]  = blk3_pkg::init_work(key_reg, s_data);

    for (genvar r = 0; r < blk3_pkg::ROUNDS; r++) begin : g_round
        blk3_step u_col (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (rnd_valid[r]),
            .in_ready  (rnd_ready[r]),
            .in_work   (rnd_work[r]),
            .out_valid (mid_valid[r]),
            .out_ready (mid_ready[r]),
            .out_work  (col_work[r])
        );

        assign diag_in[r] = blk3_pkg::diagonalize(col_work[r]);

        blk3_step u_diag (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (mid_valid[r]),
            .in_ready  (mid_ready[r]),
            .in_work   (diag_in[r]),
            .out_valid (rnd_valid[r+1]),
            .out_ready (rnd_ready[r+1]),
            .out_work  (diag_work[r])
        );

        if (r < blk3_pkg::ROUNDS - 1) begin : g_perm
            assign rnd_work[r+1] = blk3_pkg::permute(blk3_pkg::undiagonalize(diag_work[r]));
        end else begin : g_last
            assign rnd_work[r+1] = blk3_pkg::undiagonalize(diag_work[r]);
        end
    end

    assign rnd_ready[blk3_pkg::ROUNDS] = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rnd_ready[blk3_pkg::ROUNDS]) begin
            m_valid_reg <= rnd_valid[blk3_pkg::ROUNDS];
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_ready[blk3_pkg::ROUNDS] && rnd_valid[blk3_pkg::ROUNDS]) begin
            m_data_reg <= blk3_pkg::fold_digest(rnd_work[blk3_pkg::ROUNDS].v);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hw/rtl/blk3_step.sv @@
module blk3_step (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  blk3_pkg::work_t in_work,
    output logic            out_valid,
    input  logic            out_ready,
    output blk3_pkg::work_t out_work
);

    logic            half_valid_reg;
    blk3_pkg::work_t half_work_reg;
    logic            out_valid_reg;
    blk3_pkg::work_t out_work_reg;
    logic            out_stage_ready;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign in_ready        = !half_valid_reg || out_stage_ready;
    assign out_valid       = out_valid_reg;
    assign out_work        = out_work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                half_valid_reg <= in_valid;
            end
            if (out_stage_ready) begin
                out_valid_reg <= half_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            half_work_reg.v <= blk3_pkg::mix_first(in_work.v, in_work.m);
            half_work_reg.m <= in_work.m;
        end
        if (out_stage_ready && half_valid_reg) begin
            out_work_reg.v <= blk3_pkg::mix_second(half_work_reg.v, half_work_reg.m);
            out_work_reg.m <= half_work_reg.m;
        end
    end

endmodule

@@ tb/tb_blake3_keyed_block_hash_core.sv @@
`timescale 1ns / 100ps

module tb_blake3_keyed_block_hash_core;

    localparam int N_ROUNDS = 7;
    localparam int DRAIN_GAP = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_REQUESTS = 135;
    localparam int CYCLE_LIMIT = 200000;
    localparam blk3_pkg::word_t BLOCK_BYTES = 32'd64;
    localparam blk3_pkg::word_t KEYED_ROOT_FLAGS = 32'h0000001B;
    localparam blk3_pkg::word_t CHAIN_IV [4] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A
    };
    localparam int MSG_SCHEDULE [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};
    localparam int G_LANES [8][4] = '{
        '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
        '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
    };

    typedef enum logic [1:0] {
        KEY_WORDS_0_1,
        KEY_WORDS_2_3,
        KEY_WORDS_4_5,
        KEY_WORDS_6_7
    } key_reg_e;

    class digest_scoreboard;
        blk3_pkg::key_array_t key;
        blk3_pkg::digest_t pending[$];
        int errors;

        function new();
            key = '0;
            errors = 0;
        endfunction

        function blk3_pkg::word_t rotr(blk3_pkg::word_t x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void note_request(blk3_pkg::msg_t msg);
            blk3_pkg::word_t st [16];
            blk3_pkg::word_t mw [16];
            blk3_pkg::word_t nx [16];
            blk3_pkg::dword_t md [8];
            blk3_pkg::digest_t dg;
            int a;
            int b;
            int c;
            int d;
            md[0] = msg.msg_words_0_1;
            md[1] = msg.msg_words_2_3;
            md[2] = msg.msg_words_4_5;
            md[3] = msg.msg_words_6_7;
            md[4] = msg.msg_words_8_9;
            md[5] = msg.msg_words_10_11;
            md[6] = msg.msg_words_12_13;
            md[7] = msg.msg_words_14_15;
            for (int i = 0; i < 4; i++) begin
                st[2*i] = key[i][31:0];
                st[2*i+1] = key[i][63:32];
                st[8+i] = CHAIN_IV[i];
            end
            for (int i = 0; i < 8; i++) begin
                mw[2*i] = md[i][31:0];
                mw[2*i+1] = md[i][63:32];
            end
            st[12] = '0;
            st[13] = '0;
            st[14] = BLOCK_BYTES;
            st[15] = KEYED_ROOT_FLAGS;
            for (int r = 0; r < N_ROUNDS; r++) begin
                for (int j = 0; j < 8; j++) begin
                    a = G_LANES[j][0];
                    b = G_LANES[j][1];
                    c = G_LANES[j][2];
                    d = G_LANES[j][3];
                    st[a] = st[a] + st[b] + mw[2*j];
                    st[d] = rotr(st[d] ^ st[a], 16);
                    st[c] = st[c] + st[d];
                    st[b] = rotr(st[b] ^ st[c], 12);
                    st[a] = st[a] + st[b] + mw[2*j+1];
                    st[d] = rotr(st[d] ^ st[a], 8);
                    st[c] = st[c] + st[d];
                    st[b] = rotr(st[b] ^ st[c], 7);
                end
                for (int i = 0; i < 16; i++) begin
                    nx[i] = mw[MSG_SCHEDULE[i]];
                end
                mw = nx;
            end
            dg.digest_words_0_1 = {st[1] ^ st[9], st[0] ^ st[8]};
            dg.digest_words_2_3 = {st[3] ^ st[11], st[2] ^ st[10]};
            dg.digest_words_4_5 = {st[5] ^ st[13], st[4] ^ st[12]};
            dg.digest_words_6_7 = {st[7] ^ st[15], st[6] ^ st[14]};
            pending.push_back(dg);
        endfunction

        function void check_digest(blk3_pkg::digest_t got);
            blk3_pkg::digest_t want;
            if (pending.size() == 0) begin
                $error("digest returned with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.digest_words_0_1 !== want.digest_words_0_1) begin
                $error("digest_words_0_1: expected %h, got %h",
                       want.digest_words_0_1, got.digest_words_0_1);
                errors++;
            end
            if (got.digest_words_2_3 !== want.digest_words_2_3) begin
                $error("digest_words_2_3: expected %h, got %h",
                       want.digest_words_2_3, got.digest_words_2_3);
                errors++;
            end
            if (got.digest_words_4_5 !== want.digest_words_4_5) begin
                $error("digest_words_4_5: expected %h, got %h",
                       want.digest_words_4_5, got.digest_words_4_5);
                errors++;
            end
            if (got.digest_words_6_7 !== want.digest_words_6_7) begin
                $error("digest_words_6_7: expected %h, got %h",
                       want.digest_words_6_7, got.digest_words_6_7);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    blk3_pkg::msg_t s_data;
    logic m_valid;
    logic m_ready;
    blk3_pkg::digest_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [blk3_pkg::ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    digest_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;

    blake3_keyed_block_hash_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_blake3_keyed_block_hash_core: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_digest(m_data);
            end
        end
    end

    // The receiver either holds off for a counted stretch or stalls at random.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic blk3_pkg::dword_t rand_dword();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic blk3_pkg::msg_t rand_msg();
        blk3_pkg::msg_t m;
        m.msg_words_0_1 = rand_dword();
        m.msg_words_2_3 = rand_dword();
        m.msg_words_4_5 = rand_dword();
        m.msg_words_6_7 = rand_dword();
        m.msg_words_8_9 = rand_dword();
        m.msg_words_10_11 = rand_dword();
        m.msg_words_12_13 = rand_dword();
        m.msg_words_14_15 = rand_dword();
        return m;
    endfunction

    task automatic send_msg(input blk3_pkg::msg_t m);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= m;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input key_reg_e idx, input blk3_pkg::dword_t val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= blk3_pkg::ADDR_W'(idx) << blk3_pkg::REG_LSB;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.key[idx] = val;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic verify_key_regs();
        key_reg_e ri;
        for (int i = 0; i < blk3_pkg::KEY_REGS; i++) begin
            ri = key_reg_e'(i);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= blk3_pkg::ADDR_W'(i) << blk3_pkg::REG_LSB;
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            if (prdata !== sb.key[i]) begin
                $error("%s: expected %h, got %h", ri.name(), sb.key[i], prdata);
                sb.errors++;
            end
            @(negedge aclk);
            psel <= 1'b0;
            penable <= 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic load_key(input blk3_pkg::key_array_t kv);
        for (int i = 0; i < blk3_pkg::KEY_REGS; i++) begin
            apb_write(key_reg_e'(i), kv[i]);
        end
        verify_key_regs();
    endtask

    initial begin
        blk3_pkg::msg_t m;
        blk3_pkg::key_array_t kv;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        verify_key_regs();

        // The key is still zero from reset here.
        m = '0;
        send_msg(m);
        m = '1;
        send_msg(m);
        m = {8{64'hAAAA_AAAA_AAAA_AAAA}};
        send_msg(m);
        m = {8{64'h5555_5555_5555_5555}};
        send_msg(m);
        m = '0;
        m.msg_words_0_1 = 64'h8000_0000_0000_0001;
        m.msg_words_14_15 = 64'h0000_0001_8000_0000;
        send_msg(m);
        m = {4{128'hFFFF_FFFF_FFFF_FFFF_0000_0000_0000_0000}};
        send_msg(m);
        wait_drain();

        load_key('1);
        m = '0;
        send_msg(m);
        m = '1;
        send_msg(m);
        send_msg(rand_msg());
        send_msg(rand_msg());
        wait_drain();

        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < blk3_pkg::KEY_REGS; i++) begin
                kv[i] = (p == 1) ? {32'h5555_5555, 32'hAAAA_AAAA} : rand_dword();
            end
            load_key(kv);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 54;
                end
                default: begin
                    send_idle_pct = 22;
                    recv_stall_pct = 22;
                end
            endcase
            // The sender keeps offering while the receiver is held off, so the
            // pipeline fills up and pushes back on the request side.
            if (p == 0) begin
                hold_cycles = HOLD_OFF_CYCLES;
            end
            repeat (PHASE_REQUESTS) send_msg(rand_msg());
            wait_drain();
        end

        if (sb.errors == 0) begin
            $display("tb_blake3_keyed_block_hash_core: PASS");
        end else begin
            $display("tb_blake3_keyed_block_hash_core: FAIL");
        end
        $finish;
    end

endmodule
